@@ sv/u2rtf_pkg.sv @@
// u2rtf_pkg: shared types, constants, microcode store and tag tables
// for the utf-8 to rtf styled escaper; depends on nothing else
package u2rtf_pkg;

  // microcode address
  typedef logic [4:0] upc_t;

  // jump conditions
  localparam logic [3:0] C_NEVER      = 4'd0;
  localparam logic [3:0] C_ALWAYS     = 4'd1;
  localparam logic [3:0] C_NOIN       = 4'd2;
  localparam logic [3:0] C_TAG_DONE   = 4'd3;
  localparam logic [3:0] C_NOT_NEG    = 4'd4;
  localparam logic [3:0] C_DD_DONE    = 4'd5;
  localparam logic [3:0] C_DIG_DONE   = 4'd6;
  localparam logic [3:0] C_REM_NZ     = 4'd7;
  localparam logic [3:0] C_DISP_ENTRY = 4'd8;
  localparam logic [3:0] C_DISP_CLASS = 4'd9;
  localparam logic [3:0] C_DISP_FIN   = 4'd10;

  // datapath actions
  localparam logic [3:0] ACT_NONE      = 4'd0;
  localparam logic [3:0] ACT_LOAD      = 4'd1;
  localparam logic [3:0] ACT_TAG_START = 4'd2;
  localparam logic [3:0] ACT_TAG_NEXT  = 4'd3;
  localparam logic [3:0] ACT_PAR_START = 4'd4;
  localparam logic [3:0] ACT_LEAD_LOAD = 4'd5;
  localparam logic [3:0] ACT_CONT_LOAD = 4'd6;
  localparam logic [3:0] ACT_CP_INIT   = 4'd7;
  localparam logic [3:0] ACT_DD_STEP   = 4'd8;
  localparam logic [3:0] ACT_DIG_NEXT  = 4'd9;
  localparam logic [3:0] ACT_RST_STATE = 4'd10;
  localparam logic [3:0] ACT_FLUSH     = 4'd11;

  // emitted byte source
  localparam logic [2:0] EM_NONE  = 3'd0;
  localparam logic [2:0] EM_CONST = 3'd1;
  localparam logic [2:0] EM_TAG   = 3'd2;
  localparam logic [2:0] EM_BYTE  = 3'd3;
  localparam logic [2:0] EM_DIGIT = 3'd4;

  // sequencing when no jump is taken
  localparam logic [1:0] NX_INC  = 2'd0;
  localparam logic [1:0] NX_STAY = 2'd1;
  localparam logic [1:0] NX_IDLE = 2'd2;

  // microprogram labels
  localparam upc_t L_IDLE     = 5'd0;
  localparam upc_t L_ENTRY    = 5'd1;
  localparam upc_t L_CLOSE    = 5'd2;
  localparam upc_t L_OPEN     = 5'd3;
  localparam upc_t L_TAGLOOP  = 5'd4;
  localparam upc_t L_BYTE     = 5'd5;
  localparam upc_t L_ESC      = 5'd6;
  localparam upc_t L_PLAIN    = 5'd7;
  localparam upc_t L_PLAINJ   = 5'd8;
  localparam upc_t L_PAR      = 5'd9;
  localparam upc_t L_PARLOOP  = 5'd10;
  localparam upc_t L_LEAD     = 5'd11;
  localparam upc_t L_LEADJ    = 5'd12;
  localparam upc_t L_CONT     = 5'd13;
  localparam upc_t L_CONTJ    = 5'd14;
  localparam upc_t L_CP_BS    = 5'd15;
  localparam upc_t L_CP_U     = 5'd16;
  localparam upc_t L_CP_SIGN  = 5'd17;
  localparam upc_t L_CP_DD    = 5'd18;
  localparam upc_t L_CP_DIG   = 5'd19;
  localparam upc_t L_CP_Q     = 5'd20;
  localparam upc_t L_FIN      = 5'd21;
  localparam upc_t L_ENDCLOSE = 5'd22;
  localparam upc_t L_ENDRST   = 5'd23;
  localparam upc_t L_DONE     = 5'd24;

  // byte classes
  localparam logic [2:0] CLS_PLAIN = 3'd0;
  localparam logic [2:0] CLS_ESC   = 3'd1;
  localparam logic [2:0] CLS_LF    = 3'd2;
  localparam logic [2:0] CLS_CR    = 3'd3;
  localparam logic [2:0] CLS_LEAD  = 3'd4;

  // ascii codes
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [3:0] CH_DIGIT_HI = 4'h3;

  // style codes and tag rows
  localparam logic [3:0] STYLE_REGULAR = 4'd0;
  localparam logic [3:0] STYLE_BOLD    = 4'd1;
  localparam logic [3:0] STYLE_ITALIC  = 4'd2;
  localparam logic [3:0] STYLE_ULINE   = 4'd3;
  localparam logic [3:0] STYLE_HEAD1   = 4'd4;
  localparam logic [3:0] STYLE_HEAD2   = 4'd5;
  localparam logic [3:0] STYLE_HEAD3   = 4'd6;
  localparam logic [3:0] STYLE_HEAD4   = 4'd7;
  localparam logic [3:0] STYLE_BULLET  = 4'd8;
  localparam logic [3:0] STYLE_MAX     = 4'd8;
  localparam logic [3:0] ROW_PAR       = 4'd9;

  // code point conversion sizes
  localparam int CP_W   = 21;
  localparam int NDIG   = 7;
  localparam int BCD_W  = 4 * NDIG;
  localparam logic [4:0] DD_STEPS = 5'(CP_W);
  localparam logic [2:0] DIG_LAST = 3'(NDIG - 1);
  localparam logic [2:0] DIG_END  = 3'(NDIG);

  // tag text storage
  localparam int TAG_MAX = 17;
  typedef logic [TAG_MAX*8-1:0] tag_vec_t;

  typedef struct packed {
    logic [3:0] cond;
    upc_t       target;
    logic [3:0] act;
    logic [2:0] emit;
    logic [7:0] lit;
    logic [1:0] nxt;
  } uword_t;

  typedef struct packed {
    logic       rem_nz;
    logic       same_style;
    logic       cur_normal;
    logic [2:0] cls;
    logic       tag_done;
    logic       cp_neg;
    logic       dd_done;
    logic       dig_done;
    logic       dig_visible;
    logic       end_flag;
  } dp_flags_t;

  typedef struct packed {
    logic [3:0] act;
    logic [2:0] emit;
    logic [7:0] lit;
    logic       go;
  } dp_ctrl_t;

  typedef struct packed {
    logic emit_fire;
    logic flush_fire;
  } os_ctrl_t;

  typedef struct packed {
    logic stage_valid;
    logic busy;
  } os_status_t;

  function automatic uword_t uw(logic [3:0] cond, upc_t target, logic [3:0] act,
                                logic [2:0] emit, logic [7:0] lit, logic [1:0] nxt);
    uword_t w;
    w.cond   = cond;
    w.target = target;
    w.act    = act;
    w.emit   = emit;
    w.lit    = lit;
    w.nxt    = nxt;
    return w;
  endfunction

  // microprogram: a taken jump does nothing else; otherwise act, emit, advance
  function automatic uword_t ucode_rom(upc_t pc);
    uword_t w;
    case (pc)
      L_IDLE:     w = uw(C_NOIN, L_IDLE, ACT_LOAD, EM_NONE, 8'h00, NX_INC);
      L_ENTRY:    w = uw(C_DISP_ENTRY, L_IDLE, ACT_NONE, EM_NONE, 8'h00, NX_INC);
      L_CLOSE:    w = uw(C_NEVER, L_IDLE, ACT_NONE, EM_CONST, CH_RBRACE, NX_INC);
      L_OPEN:     w = uw(C_NEVER, L_IDLE, ACT_TAG_START, EM_NONE, 8'h00, NX_INC);
      L_TAGLOOP:  w = uw(C_TAG_DONE, L_BYTE, ACT_TAG_NEXT, EM_TAG, 8'h00, NX_STAY);
      L_BYTE:     w = uw(C_DISP_CLASS, L_IDLE, ACT_NONE, EM_NONE, 8'h00, NX_INC);
      L_ESC:      w = uw(C_NEVER, L_IDLE, ACT_NONE, EM_CONST, CH_BSLASH, NX_INC);
      L_PLAIN:    w = uw(C_NEVER, L_IDLE, ACT_NONE, EM_BYTE, 8'h00, NX_INC);
      L_PLAINJ:   w = uw(C_ALWAYS, L_FIN, ACT_NONE, EM_NONE, 8'h00, NX_INC);
      L_PAR:      w = uw(C_NEVER, L_IDLE, ACT_PAR_START, EM_NONE, 8'h00, NX_INC);
      L_PARLOOP:  w = uw(C_TAG_DONE, L_FIN, ACT_TAG_NEXT, EM_TAG, 8'h00, NX_STAY);
      L_LEAD:     w = uw(C_NEVER, L_IDLE, ACT_LEAD_LOAD, EM_NONE, 8'h00, NX_INC);
      L_LEADJ:    w = uw(C_ALWAYS, L_FIN, ACT_NONE, EM_NONE, 8'h00, NX_INC);
      L_CONT:     w = uw(C_NEVER, L_IDLE, ACT_CONT_LOAD, EM_NONE, 8'h00, NX_INC);
      L_CONTJ:    w = uw(C_REM_NZ, L_FIN, ACT_NONE, EM_NONE, 8'h00, NX_INC);
      L_CP_BS:    w = uw(C_NEVER, L_IDLE, ACT_CP_INIT, EM_CONST, CH_BSLASH, NX_INC);
      L_CP_U:     w = uw(C_NEVER, L_IDLE, ACT_NONE, EM_CONST, CH_U, NX_INC);
      L_CP_SIGN:  w = uw(C_NOT_NEG, L_CP_DD, ACT_NONE, EM_CONST, CH_MINUS, NX_INC);
      L_CP_DD:    w = uw(C_DD_DONE, L_CP_DIG, ACT_DD_STEP, EM_NONE, 8'h00, NX_STAY);
      L_CP_DIG:   w = uw(C_DIG_DONE, L_CP_Q, ACT_DIG_NEXT, EM_DIGIT, 8'h00, NX_STAY);
      L_CP_Q:     w = uw(C_NEVER, L_IDLE, ACT_NONE, EM_CONST, CH_QMARK, NX_INC);
      L_FIN:      w = uw(C_DISP_FIN, L_IDLE, ACT_NONE, EM_NONE, 8'h00, NX_INC);
      L_ENDCLOSE: w = uw(C_NEVER, L_IDLE, ACT_NONE, EM_CONST, CH_RBRACE, NX_INC);
      L_ENDRST:   w = uw(C_NEVER, L_IDLE, ACT_RST_STATE, EM_NONE, 8'h00, NX_INC);
      L_DONE:     w = uw(C_NEVER, L_IDLE, ACT_FLUSH, EM_NONE, 8'h00, NX_IDLE);
      default:    w = uw(C_ALWAYS, L_IDLE, ACT_NONE, EM_NONE, 8'h00, NX_IDLE);
    endcase
    return w;
  endfunction

  // tag length in bytes per row
  function automatic logic [4:0] tag_len(logic [3:0] row);
    logic [4:0] n;
    case (row)
      STYLE_BOLD, STYLE_ITALIC: n = 5'd4;
      STYLE_ULINE:              n = 5'd5;
      STYLE_HEAD1, STYLE_HEAD2, STYLE_HEAD3, STYLE_HEAD4: n = 5'd9;
      STYLE_BULLET:             n = 5'd17;
      ROW_PAR:                  n = 5'd6;
      default:                  n = 5'd0;
    endcase
    return n;
  endfunction

  // tag text, right justified: first character in the highest used byte
  function automatic tag_vec_t tag_text(logic [3:0] row);
    tag_vec_t t;
    case (row)
      STYLE_BOLD:   t = tag_vec_t'("{\\b ");
      STYLE_ITALIC: t = tag_vec_t'("{\\i ");
      STYLE_ULINE:  t = tag_vec_t'("{\\ul ");
      STYLE_HEAD1:  t = tag_vec_t'("{\\b\\fs36 ");
      STYLE_HEAD2:  t = tag_vec_t'("{\\b\\fs28 ");
      STYLE_HEAD3:  t = tag_vec_t'("{\\b\\fs24 ");
      STYLE_HEAD4:  t = tag_vec_t'("{\\b\\fs22 ");
      STYLE_BULLET: t = tag_vec_t'("{\\pntext\\'B7\\tab}");
      ROW_PAR:      t = tag_vec_t'({CH_BSLASH, "par", CH_CR, CH_LF});
      default:      t = '0;
    endcase
    return t;
  endfunction

endpackage

@@ sv/u2rtf_useq.sv @@
// u2rtf_useq: microcode sequencer with step counter, control store and dispatch
// depends on u2rtf_pkg
module u2rtf_useq (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  u2rtf_pkg::dp_flags_t  flags,
  input  u2rtf_pkg::os_status_t ost,
  output u2rtf_pkg::dp_ctrl_t   dctl,
  output u2rtf_pkg::os_ctrl_t   octl
);
  import u2rtf_pkg::*;

  upc_t   pc;
  upc_t   pc_next;
  uword_t word;
  logic   taken;
  upc_t   tgt;
  logic   emit_req;
  logic   flush_req;
  logic   hold;

  assign word = ucode_rom(pc);

  // jump condition and target, including multiway dispatch
  always_comb begin
    taken = 1'b0;
    tgt   = word.target;
    case (word.cond)
      C_NEVER:    taken = 1'b0;
      C_ALWAYS:   taken = 1'b1;
      C_NOIN:     taken = !in_valid;
      C_TAG_DONE: taken = flags.tag_done;
      C_NOT_NEG:  taken = !flags.cp_neg;
      C_DD_DONE:  taken = flags.dd_done;
      C_DIG_DONE: taken = flags.dig_done;
      C_REM_NZ:   taken = flags.rem_nz;
      C_DISP_ENTRY: begin
        taken = 1'b1;
        if (flags.rem_nz) tgt = L_CONT;
        else if (flags.same_style) tgt = L_BYTE;
        else if (flags.cur_normal) tgt = L_OPEN;
        else tgt = L_CLOSE;
      end
      C_DISP_CLASS: begin
        taken = 1'b1;
        case (flags.cls)
          CLS_ESC:  tgt = L_ESC;
          CLS_LF:   tgt = L_PAR;
          CLS_CR:   tgt = L_FIN;
          CLS_LEAD: tgt = L_LEAD;
          default:  tgt = L_PLAIN;
        endcase
      end
      C_DISP_FIN: begin
        taken = 1'b1;
        if (!flags.end_flag) tgt = L_DONE;
        else if (flags.rem_nz) tgt = L_CP_BS;
        else if (!flags.cur_normal) tgt = L_ENDCLOSE;
        else tgt = L_ENDRST;
      end
      default: begin
        taken = 1'b1;
        tgt   = L_IDLE;
      end
    endcase
  end

  // output back-pressure holds the whole step
  assign emit_req  = !taken && (word.emit != EM_NONE) &&
                     ((word.emit != EM_DIGIT) || flags.dig_visible);
  assign flush_req = !taken && (word.act == ACT_FLUSH);
  assign hold      = (emit_req || flush_req) && ost.busy;

  // step counter
  always_comb begin
    if (taken) begin
      pc_next = tgt;
    end else if (hold) begin
      pc_next = pc;
    end else begin
      case (word.nxt)
        NX_INC:  pc_next = pc + upc_t'(1);
        NX_STAY: pc_next = pc;
        default: pc_next = L_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= L_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  assign in_ready        = (pc == L_IDLE);
  assign dctl.act        = word.act;
  assign dctl.emit       = word.emit;
  assign dctl.lit        = word.lit;
  assign dctl.go         = !taken && !hold;
  assign octl.emit_fire  = emit_req && !hold;
  assign octl.flush_fire = flush_req && !hold;

endmodule

@@ sv/u2rtf_dpath.sv @@
// u2rtf_dpath: datapath for style tracking, utf-8 assembly and decimal conversion
// depends on u2rtf_pkg; driven by control words from u2rtf_useq
module u2rtf_dpath (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [7:0]           text_byte,
  input  logic [3:0]           style_code,
  input  logic                 text_end,
  input  u2rtf_pkg::dp_ctrl_t  dctl,
  output u2rtf_pkg::dp_flags_t flags,
  output logic [7:0]           emit_byte
);
  import u2rtf_pkg::*;

  logic [7:0]      byte_r;
  logic [3:0]      style_r;
  logic            end_r;
  logic [3:0]      cur_style;
  logic [1:0]      rem;
  logic [CP_W-1:0] acc;
  logic [3:0]      tag_row;
  logic [4:0]      tag_idx;
  logic            cp_neg;
  logic [CP_W-1:0] dd_bin;
  logic [BCD_W-1:0] dd_bcd;
  logic [4:0]      dd_cnt;
  logic [2:0]      dig_cnt;
  logic            started;

  logic [CP_W-1:0]  cp_pad;
  logic             neg;
  logic [CP_W-1:0]  mag;
  logic [BCD_W-1:0] bcd_adj;
  logic [3:0]       nibble;
  logic             visible;
  logic [2:0]       cls;
  logic [4:0]       tag_pos;
  tag_vec_t         tag_vec;
  logic [7:0]       tag_ch;

  // byte classification
  always_comb begin
    if (byte_r[7:6] == 2'b11 && byte_r[7:3] != 5'b11111) cls = CLS_LEAD;
    else if (byte_r == CH_BSLASH || byte_r == CH_LBRACE || byte_r == CH_RBRACE)
      cls = CLS_ESC;
    else if (byte_r == CH_LF) cls = CLS_LF;
    else if (byte_r == CH_CR) cls = CLS_CR;
    else cls = CLS_PLAIN;
  end

  // missing continuation bytes count as zero
  always_comb begin
    case (rem)
      2'd1:    cp_pad = {acc[CP_W-7:0], 6'b0};
      2'd2:    cp_pad = {acc[CP_W-13:0], 12'b0};
      2'd3:    cp_pad = {acc[CP_W-19:0], 18'b0};
      default: cp_pad = acc;
    endcase
  end

  // signed 16-bit view of the code point
  assign neg = (cp_pad[CP_W-1:15] == 6'b000001);
  always_comb begin
    if (cp_pad[CP_W-1:16] != '0) mag = cp_pad - CP_W'(32'h10000);
    else if (neg) mag = CP_W'(32'h10000) - cp_pad;
    else mag = cp_pad;
  end

  // double dabble correction, one per digit
  always_comb begin
    for (int k = 0; k < NDIG; k++) begin
      if (dd_bcd[4*k +: 4] >= 4'd5) bcd_adj[4*k +: 4] = dd_bcd[4*k +: 4] + 4'd3;
      else bcd_adj[4*k +: 4] = dd_bcd[4*k +: 4];
    end
  end

  // digit output, leading zeros suppressed
  assign nibble  = dd_bcd[BCD_W-1 -: 4];
  assign visible = started || (nibble != 4'd0) || (dig_cnt == DIG_LAST);

  // tag character lookup
  assign tag_vec = tag_text(tag_row);
  assign tag_pos = tag_len(tag_row) - tag_idx - 5'd1;
  assign tag_ch  = tag_vec[{tag_pos, 3'b000} +: 8];

  // emitted byte select
  always_comb begin
    case (dctl.emit)
      EM_TAG:   emit_byte = tag_ch;
      EM_BYTE:  emit_byte = byte_r;
      EM_DIGIT: emit_byte = {CH_DIGIT_HI, nibble};
      default:  emit_byte = dctl.lit;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_style <= STYLE_REGULAR;
      rem       <= 2'd0;
    end else if (dctl.go) begin
      case (dctl.act)
        ACT_TAG_START: cur_style <= style_r;
        ACT_LEAD_LOAD: begin
          if (byte_r[7:5] == 3'b110) rem <= 2'd1;
          else if (byte_r[7:4] == 4'b1110) rem <= 2'd2;
          else rem <= 2'd3;
        end
        ACT_CONT_LOAD: rem <= rem - 2'd1;
        ACT_CP_INIT:   rem <= 2'd0;
        ACT_RST_STATE: begin
          cur_style <= STYLE_REGULAR;
          rem       <= 2'd0;
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (dctl.go) begin
      case (dctl.act)
        ACT_LOAD: begin
          byte_r  <= text_byte;
          style_r <= (style_code > STYLE_MAX) ? STYLE_REGULAR : style_code;
          end_r   <= text_end;
        end
        ACT_TAG_START: begin
          tag_row <= style_r;
          tag_idx <= 5'd0;
        end
        ACT_PAR_START: begin
          tag_row <= ROW_PAR;
          tag_idx <= 5'd0;
        end
        ACT_TAG_NEXT: tag_idx <= tag_idx + 5'd1;
        ACT_LEAD_LOAD: begin
          if (byte_r[7:5] == 3'b110) acc <= CP_W'(byte_r[4:0]);
          else if (byte_r[7:4] == 4'b1110) acc <= CP_W'(byte_r[3:0]);
          else acc <= CP_W'(byte_r[2:0]);
        end
        ACT_CONT_LOAD: acc <= {acc[CP_W-7:0], byte_r[5:0]};
        ACT_CP_INIT: begin
          cp_neg  <= neg;
          dd_bin  <= mag;
          dd_bcd  <= '0;
          dd_cnt  <= 5'd0;
          dig_cnt <= 3'd0;
          started <= 1'b0;
        end
        ACT_DD_STEP: begin
          dd_bcd <= {bcd_adj[BCD_W-2:0], dd_bin[CP_W-1]};
          dd_bin <= {dd_bin[CP_W-2:0], 1'b0};
          dd_cnt <= dd_cnt + 5'd1;
        end
        ACT_DIG_NEXT: begin
          dd_bcd  <= {dd_bcd[BCD_W-5:0], 4'd0};
          dig_cnt <= dig_cnt + 3'd1;
          started <= visible;
        end
        ACT_RST_STATE: acc <= '0;
        default: ;
      endcase
    end
  end

  assign flags.rem_nz      = (rem != 2'd0);
  assign flags.same_style  = (style_r == cur_style);
  assign flags.cur_normal  = (cur_style == STYLE_REGULAR);
  assign flags.cls         = cls;
  assign flags.tag_done    = (tag_idx == tag_len(tag_row));
  assign flags.cp_neg      = cp_neg;
  assign flags.dd_done     = (dd_cnt == DD_STEPS);
  assign flags.dig_done    = (dig_cnt == DIG_END);
  assign flags.dig_visible = visible;
  assign flags.end_flag    = end_r;

endmodule

@@ sv/u2rtf_ostage.sv @@
// u2rtf_ostage: one-byte lookahead stage that marks the final byte of a
// transaction, followed by the output register; depends on u2rtf_pkg
module u2rtf_ostage (
  input  logic                  clk,
  input  logic                  rst,
  input  u2rtf_pkg::os_ctrl_t   octl,
  input  logic [7:0]            emit_byte,
  output u2rtf_pkg::os_status_t ost,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_byte,
  output logic                  run_last
);
  import u2rtf_pkg::*;

  logic       stage_valid;
  logic [7:0] stage_byte;
  logic       out_free;
  logic       move;

  assign out_free = !out_valid || out_ready;
  // stage moves forward on a new byte or at the end of the item
  assign move     = stage_valid && (octl.emit_fire || octl.flush_fire);

  // valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      out_valid <= move || (out_valid && !out_ready);
      if (octl.emit_fire) stage_valid <= 1'b1;
      else if (octl.flush_fire) stage_valid <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (octl.emit_fire) stage_byte <= emit_byte;
    if (move) begin
      out_byte <= stage_byte;
      run_last <= octl.flush_fire;
    end
  end

  assign ost.stage_valid = stage_valid;
  assign ost.busy        = stage_valid && !out_free;

endmodule

@@ sv/utf8_to_rtf_styled_escaper.sv @@
// utf8_to_rtf_styled_escaper: top level of the utf-8 to rtf body escaper
// depends on u2rtf_pkg, u2rtf_useq, u2rtf_dpath, u2rtf_ostage
//
// Input channel (in_valid/in_ready): one utf-8 byte per transaction with its
// style code and an end-of-text flag. Output channel (out_valid/out_ready):
// one rtf body byte per transaction; run_last marks the final byte caused by
// an input byte (a CR or non-final utf-8 byte with no style change gives none).
// One input is processed at a time by a microcoded sequencer; in_ready is high
// only while it waits at its idle step. A style change emits the new style's
// opening tag, after a closing brace when a style was open; an escaped
// character is preceded by a backslash, a newline becomes a par control word
// with CR LF, and a finished code point goes out as backslash, u, an optional
// minus, its decimal digits and a question mark, converted by double dabble
// over 21 bits into 7 digit slots. End of text converts a cut sequence and
// closes an open style. Each byte waits in a one-byte lookahead stage until
// the next byte of the same input or the final flush step, then moves to the
// output register.
// When the receiver stalls, the sequencer holds at its emitting step and
// resumes without loss. Reset (rst, synchronous) returns to normal style with
// no pending sequence and empties the output path.
module utf8_to_rtf_styled_escaper (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] text_byte,
  input  logic [3:0] style_code,
  input  logic       text_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       run_last
);
  import u2rtf_pkg::*;

  dp_flags_t  flags;
  dp_ctrl_t   dctl;
  os_ctrl_t   octl;
  os_status_t ost;
  logic [7:0] emit_byte;

  // sequencer
  u2rtf_useq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .flags    (flags),
    .ost      (ost),
    .dctl     (dctl),
    .octl     (octl)
  );

  // datapath
  u2rtf_dpath u_dp (
    .clk        (clk),
    .rst        (rst),
    .text_byte  (text_byte),
    .style_code (style_code),
    .text_end   (text_end),
    .dctl       (dctl),
    .flags      (flags),
    .emit_byte  (emit_byte)
  );

  // output path
  u2rtf_ostage u_os (
    .clk       (clk),
    .rst       (rst),
    .octl      (octl),
    .emit_byte (emit_byte),
    .ost       (ost),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .run_last  (run_last)
  );

`ifndef SYNTHESIS
  // every byte of the previous input has left the stage before a new one
  a_idle_stage_empty: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !ost.stage_valid)
    else $error("new input accepted with an unflushed output byte");

  // no byte is emitted into a stage that cannot move forward
  a_emit_not_blocked: assert property (@(posedge clk) disable iff (rst)
    octl.emit_fire |-> !ost.busy)
    else $error("byte emitted while output path is blocked");

  // flushing a held byte presents it as the last byte of the input
  a_flush_marks_last: assert property (@(posedge clk) disable iff (rst)
    (octl.flush_fire && ost.stage_valid) |=> (out_valid && run_last))
    else $error("final byte of an input not marked last");
`endif

endmodule
